// ===== rtl/assert_macros.svh =====
// Assertion macros for the time window mean/sigma block.
// Used by the controller; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TWMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TWMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/twms_pkg.sv =====
// Shared types and constants for the time window mean/sigma block.
// No dependencies.
package twms_pkg;

   localparam int TS_W     = 32;
   localparam int SAMPLE_W = 16;
   localparam int WIN_W    = 16;
   localparam int MEAN_W   = 16;
   localparam int SIGMA_W  = 16;
   localparam int COUNT_W  = 9;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd60;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_ACC,
      ST_MUL,
      ST_SUB,
      ST_DIVM_GO,
      ST_DIVM,
      ST_DIVV_GO,
      ST_DIVV,
      ST_SQRT_GO,
      ST_SQRT,
      ST_EMIT
   } twms_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic mul;
      logic sub;
      logic div_mean;
      logic div_var;
      logic sqrt_go;
      logic emit;
   } twms_cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
      logic full;
      logic div_busy;
      logic sqrt_busy;
      logic out_busy;
   } twms_sts_type;

endpackage

// ===== rtl/twms_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by twms_datapath.
module twms_div #(
   parameter int DW = 49,
   parameter int VW = 18
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);
   localparam int CNT_W = $clog2(DW + 1);

   logic [VW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [VW-1:0]    dvs_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [VW:0]      shifted;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNT_W'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? VW'(shifted - {1'b0, dvs_ff}) : shifted[VW-1:0];
         quo_in  = {quo_ff[DW-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

// ===== rtl/twms_sqrt.sv =====
// Integer square root, two radicand bits per cycle.
// Depends on nothing; used by twms_datapath.
module twms_sqrt #(
   parameter int IW = 49
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [IW-1:0]       radicand,
   output logic                busy,
   output logic [(IW+1)/2-1:0] root
);
   localparam int RW    = (IW + 1) / 2;
   localparam int CNT_W = $clog2(RW + 1);

   logic [2*RW-1:0]  src_ff, src_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [RW-1:0]    root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [RW+1:0]    shifted;
   logic [RW+1:0]    trial;
   logic             fits;

   assign shifted = {rem_ff, src_ff[2*RW-1 -: 2]};
   assign trial   = {root_ff, 2'b01};
   assign fits    = shifted >= trial;

   always_comb begin
      src_in  = src_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         src_in  = (2*RW)'(radicand);
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(RW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         src_in  = {src_ff[2*RW-3:0], 2'b00};
         rem_in  = fits ? RW'(shifted - trial) : RW'(shifted);
         root_in = {root_ff[RW-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      src_ff  <= src_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule

// ===== rtl/twms_datapath.sv =====
// Datapath: sample rings, window accumulators, multipliers, output register.
// Depends on twms_pkg, twms_div and twms_sqrt.
module twms_datapath #(
   parameter int RING_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  twms_pkg::twms_cmd_type            cmd,
   output twms_pkg::twms_sts_type            sts,
   input  logic                              csr_wr_en,
   input  logic [twms_pkg::WIN_W-1:0]        csr_wr_data,
   input  logic [twms_pkg::TS_W-1:0]         in_timestamp,
   input  logic signed [twms_pkg::SAMPLE_W-1:0] in_sample,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [47:0]                       rsp_tdata,
   output logic                              rsp_tuser
);
   import twms_pkg::*;

   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int SW = SAMPLE_W + CW;
   localparam int QW = 2 * SAMPLE_W - 1 + CW;
   localparam int NW = QW + CW;
   localparam int BW = 2 * SW;
   localparam int VW = 2 * CW;
   localparam int RW = (NW + 1) / 2;

   logic [TS_W-1:0]     time_mem  [RING_DEPTH];
   logic [SAMPLE_W-1:0] value_mem [RING_DEPTH];

   logic [AW-1:0]          wp_ff, wp_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          k_ff, k_in;
   logic [TS_W-1:0]        tnew_ff;
   logic [WIN_W-1:0]       win_ff;
   logic [TS_W-1:0]        rd_time_ff;
   logic signed [SAMPLE_W-1:0] rd_val_ff;
   logic signed [SW-1:0]   sum_ff;
   logic [QW-1:0]          sumsq_ff;
   logic                   trunc_ff;
   logic [NW-1:0]          a_ff;
   logic [BW-1:0]          b_ff;
   logic [VW-1:0]          nsq_ff;
   logic [NW-1:0]          num_ff;
   logic [MEAN_W-1:0]      mean_ff;
   logic                   rsp_valid_ff;
   logic [47:0]            rsp_data_ff;
   logic                   rsp_user_ff;

   logic signed [2*SAMPLE_W-1:0] sq;
   logic [SW-1:0]          abs_sum;
   logic [TS_W-1:0]        age;
   logic                   hit;
   logic                   div_start;
   logic [NW-1:0]          div_dividend;
   logic [VW-1:0]          div_divisor;
   logic                   div_busy;
   logic [NW-1:0]          div_quo;
   logic                   sqrt_busy;
   logic [RW-1:0]          root;
   logic [SIGMA_W-1:0]     sigma;

   assign sq      = rd_val_ff * rd_val_ff;
   assign abs_sum = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
   assign age     = tnew_ff - rd_time_ff;
   assign hit     = (k_ff != '0) && (tnew_ff >= rd_time_ff)
                    && (age >= TS_W'(win_ff));

   assign wp_in   = (wp_ff == AW'(RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign fill_in = (fill_ff == CW'(RING_DEPTH)) ? fill_ff : fill_ff + 1'b1;
   assign idx_in  = (idx_ff == '0) ? AW'(RING_DEPTH - 1) : idx_ff - 1'b1;
   assign k_in    = k_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         time_mem[wp_ff]  <= in_timestamp;
         value_mem[wp_ff] <= in_sample;
      end
      rd_time_ff <= time_mem[idx_ff];
      rd_val_ff  <= value_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
         win_ff  <= WINDOW_RESET;
      end else begin
         if (cmd.load) begin
            wp_ff   <= wp_in;
            fill_ff <= fill_in;
         end
         if (csr_wr_en) begin
            win_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff   <= wp_ff;
         k_ff     <= '0;
         tnew_ff  <= in_timestamp;
         sum_ff   <= '0;
         sumsq_ff <= '0;
      end else if (cmd.step) begin
         idx_ff   <= idx_in;
         k_ff     <= k_in;
         sum_ff   <= sum_ff + SW'(rd_val_ff);
         sumsq_ff <= sumsq_ff + QW'(sq[2*SAMPLE_W-2:0]);
         trunc_ff <= !hit;
      end
      if (cmd.mul) begin
         a_ff   <= NW'(k_ff) * NW'(sumsq_ff);
         b_ff   <= BW'(abs_sum) * BW'(abs_sum);
         nsq_ff <= VW'(k_ff) * VW'(k_ff);
      end
      if (cmd.sub) begin
         num_ff <= (BW'(a_ff) >= b_ff) ? a_ff - NW'(b_ff) : '0;
      end
      if (cmd.div_var) begin
         mean_ff <= sum_ff[SW-1] ? MEAN_W'(~div_quo[MEAN_W-1:0] + 1'b1)
                                 : div_quo[MEAN_W-1:0];
      end
   end

   assign div_start    = cmd.div_mean || cmd.div_var;
   assign div_dividend = cmd.div_var ? num_ff : NW'(abs_sum);
   assign div_divisor  = cmd.div_var ? nsq_ff : VW'(k_ff);

   twms_div #(
      .DW(NW),
      .VW(VW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   twms_sqrt #(
      .IW(NW)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_go),
      .radicand (div_quo),
      .busy     (sqrt_busy),
      .root     (root)
   );

   assign sigma = (root[RW-1:SIGMA_W] != '0) ? '1 : root[SIGMA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_data_ff <= {7'b0, COUNT_W'(k_ff), sigma, mean_ff};
         rsp_user_ff <= trunc_ff;
      end
   end

   assign sts.hit       = hit;
   assign sts.last      = k_ff == fill_ff - 1'b1;
   assign sts.full      = fill_ff == CW'(RING_DEPTH);
   assign sts.div_busy  = div_busy;
   assign sts.sqrt_busy = sqrt_busy;
   assign sts.out_busy  = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule

// ===== rtl/twms_ctrl.sv =====
// Controller: sequences ring walk, multiply, divide, root and output load.
// Depends on twms_pkg and assert_macros.svh.
`include "assert_macros.svh"
module twms_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output twms_pkg::twms_cmd_type cmd,
   input  twms_pkg::twms_sts_type sts
);
   import twms_pkg::*;

   twms_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_READ;
         end
         ST_READ:    state_in = ST_ACC;
         ST_ACC: begin
            if (sts.hit) begin
               state_in = ST_MUL;
            end else if (sts.last) begin
               state_in = sts.full ? ST_MUL : ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_MUL:     state_in = ST_SUB;
         ST_SUB:     state_in = ST_DIVM_GO;
         ST_DIVM_GO: state_in = ST_DIVM;
         ST_DIVM: begin
            if (!sts.div_busy) state_in = ST_DIVV_GO;
         end
         ST_DIVV_GO: state_in = ST_DIVV;
         ST_DIVV: begin
            if (!sts.div_busy) state_in = ST_SQRT_GO;
         end
         ST_SQRT_GO: state_in = ST_SQRT;
         ST_SQRT: begin
            if (!sts.sqrt_busy) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!sts.out_busy) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_ACC:     cmd.step     = 1'b1;
         ST_MUL:     cmd.mul      = 1'b1;
         ST_SUB:     cmd.sub      = 1'b1;
         ST_DIVM_GO: cmd.div_mean = 1'b1;
         ST_DIVV_GO: cmd.div_var  = 1'b1;
         ST_SQRT_GO: cmd.sqrt_go  = 1'b1;
         ST_EMIT:    cmd.emit     = !sts.out_busy;
         default: begin
         end
      endcase
   end

   `TWMS_ASSERT_NOW(a_emit_free, clock, reset, cmd.emit, !sts.out_busy, "output overwritten")
   `TWMS_ASSERT_NEXT(a_load_walk, clock, reset, cmd.load, state_ff == ST_READ, "walk not started")
   `TWMS_ASSERT_NOW(a_div_idle, clock, reset, cmd.div_mean || cmd.div_var, !sts.div_busy, "divider restarted while busy")
   `TWMS_ASSERT_NOW(a_root_ready, clock, reset, cmd.sqrt_go, !sts.div_busy, "root started on unfinished quotient")
endmodule

// ===== rtl/time_window_mean_sigma_core.sv =====
// Top level of the time window mean/sigma block.
// Depends on twms_pkg, twms_ctrl and twms_datapath.
//
// Usage: one word on req_ carries a timestamp and a signed sample. The block stores
// it in a ring of RING_DEPTH entries and walks back from the newest entry, summing
// values and squares until it meets a sample at least window_seconds older (or the
// oldest entry when the ring is full). Then a multiply step, two serial divides
// (mean, variance) and a serial root follow. One word is worked at a time;
// req_tready is high only while the block is idle. A word whose window has no old
// enough sample yields no rsp_ word unless the ring is full. The result sits in
// an output register; a new word is taken while it waits, and the next result
// stalls only until that register is read. Reset clears the ring pointer, fill
// count, output valid and sets the window to 60. csr_wr_en writes window_seconds;
// write it only while idle.
module time_window_mean_sigma_core #(
   parameter int RING_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,   // window_seconds
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,     // timestamp[31:0], sample[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,     // mean[15:0], sigma[31:16], sample_count[40:32]
   output logic        rsp_tuser      // truncated
);
   import twms_pkg::*;

   twms_cmd_type cmd;
   twms_sts_type sts;

   twms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   twms_datapath #(
      .RING_DEPTH(RING_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .in_timestamp (req_tdata[TS_W-1:0]),
      .in_sample    (req_tdata[TS_W +: SAMPLE_W]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );
endmodule
